// File: sv/semaphore_wait_queue_table_core_assert.svh
// Assertion macros used by the core RTL file
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_CORE_ASSERT_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define SWQT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define SWQT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/swqt_pkg.sv
`default_nettype none
package swqt_pkg;
  localparam int unsigned NPROC     = 32;
  localparam int unsigned PROC_BITS = 5;
  localparam int unsigned IN_BITS   = 40;
  localparam int unsigned OUT_BITS  = 8;

  typedef enum logic [1:0] {
    CMD_BLOCK   = 2'd0,
    CMD_UNBLOCK = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_PEEK    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_RSVD      = 2'd3
  } status_e;
endpackage
`default_nettype wire

// File: sv/semaphore_wait_queue_table_core.sv
// Channel    Dir  tdata fields (low bit up)                 Notes
// s_axis     in   cmd[1:0] sem_key[33:2] proc_id[38:34]      one command word
// m_axis     out  status[1:0] proc_valid[2] result_proc[7:3] one result word
//
// Flow: one word in flight; after accept, a key search reads one slot per cycle
// (remove adds one key read first), and unblock and remove then walk the queue
// entry by entry through S_WCHK and S_WRD before the result is registered.
// Reset: rst_ni clears all descriptors to free and all processes unblocked.
// Stalls: a held result stalls only the result step (S_DONE) of the next command.
`default_nettype none
module semaphore_wait_queue_table_core
  import swqt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 32,
  parameter int unsigned KEY_BITS  = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [IN_BITS-1:0]  s_axis_tdata,  // cmd, sem_key, proc_id
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [OUT_BITS-1:0] m_axis_tdata   // status, proc_valid, result_proc
);
  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam int unsigned KW = KEY_BITS;
  localparam int unsigned DW = KW + 2 * PROC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_RKEY, S_SRCH, S_WCHK, S_WRD, S_DONE
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic [KW-1:0]        key_q, key_d;
  logic [PROC_BITS-1:0] p_q, p_d, head_q, head_d, tail_q, tail_d;
  logic [PROC_BITS-1:0] cur_q, cur_d, prev_q, prev_d;
  logic                 first_q, first_d;
  logic [PROC_BITS:0]   steps_q, steps_d;
  logic [SW:0]          cnt_q, cnt_d;
  logic                 rv_q, rv_d;
  logic [SW-1:0]        raddr_q, raddr_d, free_q, free_d, slot_q, slot_d;
  logic                 free_ok_q, free_ok_d;
  status_e              res_st_q, res_st_d;
  logic                 res_v_q, res_v_d;
  logic [PROC_BITS-1:0] res_p_q, res_p_d;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [NPROC-1:0]     blocked_q, blocked_d;
  logic                 mval_q, mval_d;
  logic [OUT_BITS-1:0]  mdat_q, mdat_d;

  // RAM ports
  logic                 sl_we, nx_we, bk_we;
  logic [SW-1:0]        sl_waddr, sl_raddr;
  logic [DW-1:0]        sl_wdata, sl_rdata;
  logic [PROC_BITS-1:0] nx_waddr, nx_raddr, nx_wdata, nx_rdata;
  logic [PROC_BITS-1:0] bk_waddr, bk_raddr;
  logic [KW-1:0]        bk_wdata, bk_rdata;

  // input word fields
  cmd_e                 in_cmd;
  logic [KW-1:0]        in_key;
  logic [PROC_BITS-1:0] in_p;
  assign in_cmd = cmd_e'(s_axis_tdata[1:0]);
  assign in_key = KW'({{KW{1'b0}}, s_axis_tdata[33:2]});
  assign in_p   = s_axis_tdata[38:34];

  // slot word: {tail, head, key}
  logic [KW-1:0]        sl_key;
  logic [PROC_BITS-1:0] sl_head, sl_tail;
  logic                 hit, scan_end, is_last, is_match;
  assign sl_key   = sl_rdata[KW-1:0];
  assign sl_head  = sl_rdata[KW+PROC_BITS-1:KW];
  assign sl_tail  = sl_rdata[DW-1:KW+PROC_BITS];
  assign hit      = rv_q && active_q[raddr_q] && (sl_key == key_q);
  assign scan_end = rv_q && (raddr_q == SW'(NUM_SLOTS - 1));
  assign is_last  = (cur_q == tail_q);
  assign is_match = (cur_q == p_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdat_q;
  assign bk_raddr      = in_p;

  swqt_ram #(.WIDTH(DW), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk_i, .we_i(sl_we), .waddr_i(sl_waddr), .wdata_i(sl_wdata),
    .raddr_i(sl_raddr), .rdata_o(sl_rdata)
  );
  swqt_ram #(.WIDTH(PROC_BITS), .DEPTH(NPROC)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );
  swqt_ram #(.WIDTH(KW), .DEPTH(NPROC)) u_bkey_ram (
    .clk_i, .we_i(bk_we), .waddr_i(bk_waddr), .wdata_i(bk_wdata),
    .raddr_i(bk_raddr), .rdata_o(bk_rdata)
  );

  // command sequencer
  always_comb begin
    state_d = state_q;  cmd_d = cmd_q;   key_d = key_q;   p_d = p_q;
    head_d = head_q;    tail_d = tail_q; cur_d = cur_q;   prev_d = prev_q;
    first_d = first_q;  steps_d = steps_q; cnt_d = cnt_q; rv_d = 1'b0;
    raddr_d = raddr_q;  free_d = free_q; free_ok_d = free_ok_q; slot_d = slot_q;
    res_st_d = res_st_q; res_v_d = res_v_q; res_p_d = res_p_q;
    active_d = active_q; blocked_d = blocked_q;
    mval_d = mval_q;    mdat_d = mdat_q;
    sl_we = 1'b0; sl_waddr = slot_q; sl_wdata = {tail_q, head_q, key_q};
    sl_raddr = cnt_q[SW-1:0];
    nx_we = 1'b0; nx_waddr = prev_q; nx_wdata = nx_rdata; nx_raddr = cur_q;
    bk_we = 1'b0; bk_waddr = p_q; bk_wdata = key_q;

    if (mval_q && m_axis_tready) begin
      mval_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = in_cmd; key_d = in_key; p_d = in_p;
          cnt_d = '0; free_ok_d = 1'b0;
          res_st_d = STAT_OK; res_v_d = 1'b0; res_p_d = '0;
          unique case (in_cmd)
            CMD_BLOCK: begin
              if (blocked_q[in_p]) begin
                res_st_d = STAT_NOT_FOUND; state_d = S_DONE;
              end else begin
                state_d = S_SRCH;
              end
            end
            CMD_REMOVE: begin
              if (!blocked_q[in_p]) begin
                res_st_d = STAT_NOT_FOUND; state_d = S_DONE;
              end else begin
                state_d = S_RKEY;
              end
            end
            default: state_d = S_SRCH;
          endcase
        end
      end
      S_RKEY: begin
        key_d = bk_rdata; state_d = S_SRCH;
      end
      S_SRCH: begin
        // issue one slot read per cycle, note first free slot
        if (cnt_q < (SW+1)'(NUM_SLOTS)) begin
          rv_d = 1'b1; raddr_d = cnt_q[SW-1:0]; cnt_d = cnt_q + 1'b1;
          if (!active_q[cnt_q[SW-1:0]] && !free_ok_q) begin
            free_ok_d = 1'b1; free_d = cnt_q[SW-1:0];
          end
        end
        if (hit) begin
          slot_d = raddr_q; head_d = sl_head; tail_d = sl_tail;
          cur_d = sl_head; first_d = 1'b1; steps_d = '0;
          unique case (cmd_q)
            CMD_BLOCK: begin
              nx_we = 1'b1; nx_waddr = sl_tail; nx_wdata = p_q;
              sl_we = 1'b1; sl_waddr = raddr_q; sl_wdata = {p_q, sl_head, key_q};
              bk_we = 1'b1; blocked_d[p_q] = 1'b1;
              state_d = S_DONE;
            end
            CMD_PEEK: begin
              res_v_d = 1'b1; res_p_d = sl_head; state_d = S_DONE;
            end
            CMD_UNBLOCK: begin
              p_d = sl_head; res_v_d = 1'b1; res_p_d = sl_head; state_d = S_WCHK;
            end
            default: state_d = S_WCHK;
          endcase
        end else if (scan_end) begin
          if (cmd_q == CMD_BLOCK) begin
            if (free_ok_q) begin
              sl_we = 1'b1; sl_waddr = free_q; sl_wdata = {p_q, p_q, key_q};
              active_d[free_q] = 1'b1;
              bk_we = 1'b1; blocked_d[p_q] = 1'b1;
            end else begin
              res_st_d = STAT_NO_FREE;
            end
          end else begin
            res_st_d = STAT_NOT_FOUND;
          end
          state_d = S_DONE;
        end
      end
      S_WCHK: begin
        // read next pointer of current entry
        if (steps_q == (PROC_BITS+1)'(NPROC)) begin
          if (cmd_q == CMD_REMOVE) res_st_d = STAT_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        if (is_match) begin
          if (first_q) begin
            if (is_last) begin
              active_d[slot_q] = 1'b0;
            end else begin
              sl_we = 1'b1; sl_wdata = {tail_q, nx_rdata, key_q};
            end
          end else begin
            nx_we = 1'b1;
            if (is_last) begin
              sl_we = 1'b1; sl_wdata = {prev_q, head_q, key_q};
            end
          end
          blocked_d[p_q] = 1'b0;
          if (cmd_q == CMD_REMOVE) begin
            res_v_d = 1'b1; res_p_d = p_q;
          end
          state_d = S_DONE;
        end else if (is_last) begin
          if (cmd_q == CMD_REMOVE) res_st_d = STAT_NOT_FOUND;
          state_d = S_DONE;
        end else begin
          prev_d = cur_q; cur_d = nx_rdata; first_d = 1'b0;
          steps_d = steps_q + 1'b1; state_d = S_WCHK;
        end
      end
      S_DONE: begin
        if (!mval_q || m_axis_tready) begin
          mval_d = 1'b1;
          mdat_d = {res_p_q, res_v_q, res_st_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; active_q <= '0; blocked_q <= '0;
      mval_q <= 1'b0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; active_q <= active_d; blocked_q <= blocked_d;
      mval_q <= mval_d; rv_q <= rv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;   key_q <= key_d;   p_q <= p_d;
    head_q <= head_d; tail_q <= tail_d; cur_q <= cur_d; prev_q <= prev_d;
    first_q <= first_d; steps_q <= steps_d; cnt_q <= cnt_d;
    raddr_q <= raddr_d; free_q <= free_d; free_ok_q <= free_ok_d; slot_q <= slot_d;
    res_st_q <= res_st_d; res_v_q <= res_v_d; res_p_q <= res_p_d;
    mdat_q <= mdat_d;
  end

`include "semaphore_wait_queue_table_core_assert.svh"
  `SWQT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, state_q != S_IDLE)
  `SWQT_ASSERT_IMP(a_status_legal, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] != STAT_RSVD)
  `SWQT_ASSERT_IMP(a_proc_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[7:3] == '0)
  `SWQT_ASSERT_IMP(a_valid_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1:0] == STAT_OK)
endmodule
`default_nettype wire

// File: sv/swqt_ram.sv
`default_nettype none
// Simple dual-port RAM, registered read
module swqt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: bench/semaphore_wait_queue_table_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module semaphore_wait_queue_table_checker
  import swqt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [IN_BITS-1:0]  s_axis_tdata,  // cmd, sem_key, proc_id
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [OUT_BITS-1:0] m_axis_tdata,  // status, proc_valid, result_proc
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       answered_o
);

  typedef struct packed {
    logic [4:0] proc_id;
    logic [1:0] proc_valid;
    status_e    status;
  } outcome_t;

  // shadow of the descriptor pool and process table
  logic [31:0] slot_key    [NUM_SLOTS];
  logic        slot_busy   [NUM_SLOTS];
  logic [4:0]  slot_head   [NUM_SLOTS];
  logic [4:0]  slot_tail   [NUM_SLOTS];
  logic [4:0]  link_next   [NPROC];
  logic [31:0] waiting_key [NPROC];
  logic        is_waiting  [NPROC];

  outcome_t outcome_q[$];

  function automatic int lookup_slot(logic [31:0] key);
    for (int s = 0; s < NUM_SLOTS; s++)
      if (slot_busy[s] && slot_key[s] == key) return s;
    return -1;
  endfunction

  // take p out of the queue of slot s, freeing the slot when it empties
  function automatic bit detach(int s, logic [4:0] p);
    logic [4:0] cur;
    logic [4:0] prev;
    bit first;
    cur = slot_head[s];
    prev = '0;
    first = 1'b1;
    for (int n = 0; n < NPROC; n++) begin
      if (cur == p) begin
        if (first) begin
          if (slot_tail[s] == cur) slot_busy[s] = 1'b0;
          else slot_head[s] = link_next[cur];
        end else begin
          link_next[prev] = link_next[cur];
          if (slot_tail[s] == cur) slot_tail[s] = prev;
        end
        is_waiting[p] = 1'b0;
        return 1'b1;
      end
      if (cur == slot_tail[s]) return 1'b0;
      prev = cur;
      cur = link_next[cur];
      first = 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t apply_command(cmd_e cmd, logic [31:0] key, logic [4:0] p);
    outcome_t r;
    int s;
    r = '{proc_id: '0, proc_valid: '0, status: STAT_OK};
    case (cmd)
      CMD_BLOCK: begin
        if (is_waiting[p]) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          s = lookup_slot(key);
          if (s < 0) begin
            for (int f = 0; f < NUM_SLOTS && s < 0; f++)
              if (!slot_busy[f]) s = f;
            if (s < 0) begin
              r.status = STAT_NO_FREE;
            end else begin
              slot_busy[s] = 1'b1;
              slot_key[s] = key;
              slot_head[s] = p;
              slot_tail[s] = p;
            end
          end else begin
            link_next[slot_tail[s]] = p;
            slot_tail[s] = p;
          end
          if (r.status == STAT_OK) begin
            waiting_key[p] = key;
            is_waiting[p] = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        s = is_waiting[p] ? lookup_slot(waiting_key[p]) : -1;
        if (s >= 0 && detach(s, p)) begin
          r.proc_valid = 1;
          r.proc_id = p;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        s = lookup_slot(key);
        if (s < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.proc_valid = 1;
          r.proc_id = slot_head[s];
          if (cmd == CMD_UNBLOCK) void'(detach(s, slot_head[s]));
        end
      end
    endcase
    return r;
  endfunction

  assign pending_o = outcome_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    int errs;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) slot_busy[s] <= 1'b0;
      for (int i = 0; i < NPROC; i++) is_waiting[i] <= 1'b0;
      outcome_q.delete();
      fail_count_o <= 0;
      answered_o <= 0;
    end else begin
      errs = 0;
      // result side first: a result never belongs to a word taken this edge
      if (m_axis_tvalid && m_axis_tready) begin
        answered_o <= answered_o + 1;
        if (outcome_q.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          errs++;
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tdata[1:0] != want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
            errs++;
          end
          if (m_axis_tdata[2] != want.proc_valid[0]) begin
            $error("proc_valid: expected %0d, got %0d", want.proc_valid[0],
                   m_axis_tdata[2]);
            errs++;
          end
          if (m_axis_tdata[7:3] != want.proc_id) begin
            $error("result_proc: expected %0d, got %0d", want.proc_id,
                   m_axis_tdata[7:3]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      if (s_axis_tvalid && s_axis_tready)
        outcome_q.push_back(apply_command(cmd_e'(s_axis_tdata[1:0]),
                                          s_axis_tdata[33:2], s_axis_tdata[38:34]));
    end
  end

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import swqt_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1600;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0] m_axis_tdata;
  int                  fail_count;
  int                  pending;
  int                  answered;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  hold_cycles = 0;
  longint unsigned     cycle_count = 0;
  logic [31:0]         key_pool [6];

  always #5 clk_i = ~clk_i;

  semaphore_wait_queue_table_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  semaphore_wait_queue_table_checker checker_u (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .answered_o(answered)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("semaphore_wait_queue_table_core regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one word and wait until it is taken; valid stays up into the next
  // word unless the sender idles or drains
  task automatic send_word(cmd_e cmd, logic [31:0] key, logic [4:0] p);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tdata <= {1'b0, p, key, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // mostly keys from a small pool so queues grow; sometimes a fresh key
  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(5)];
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    key_pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0001, 32'h1234_5678,
                 32'h5A5A_A5A5, 32'h0000_0040};

    // directed: empty table, edge keys, one queue, every command
    send_word(CMD_UNBLOCK, 32'h0, 5'd0);
    send_word(CMD_PEEK, 32'hFFFF_FFFF, 5'd31);
    send_word(CMD_REMOVE, 32'h0, 5'd31);
    send_word(CMD_BLOCK, 32'hFFFF_FFFF, 5'd31);
    send_word(CMD_BLOCK, 32'hFFFF_FFFF, 5'd0);
    send_word(CMD_BLOCK, 32'hFFFF_FFFF, 5'd7);
    send_word(CMD_BLOCK, 32'h0, 5'd0);        // already blocked
    send_word(CMD_PEEK, 32'hFFFF_FFFF, 5'd0);
    send_word(CMD_REMOVE, 32'h0, 5'd0);       // middle of queue
    send_word(CMD_REMOVE, 32'h0, 5'd7);       // tail of queue
    send_word(CMD_UNBLOCK, 32'hFFFF_FFFF, 5'd0);
    send_word(CMD_UNBLOCK, 32'hFFFF_FFFF, 5'd0); // descriptor freed
    // fill every descriptor, empty them all, then reuse one
    for (int i = 0; i < 32; i++) send_word(CMD_BLOCK, 32'hC000_0000 + i, 5'(i));
    drain();
    for (int i = 0; i < 32; i++) send_word(CMD_REMOVE, '0, 5'(i));
    send_word(CMD_BLOCK, 32'hC000_0000, 5'd3);
    send_word(CMD_REMOVE, '0, 5'd3);
    drain();
    // 31 descriptors: last process joins an existing key, then blocks again
    for (int i = 0; i < 31; i++) send_word(CMD_BLOCK, 32'hD000_0000 + i, 5'(i));
    send_word(CMD_BLOCK, 32'hD000_0000, 5'd31);
    send_word(CMD_BLOCK, 32'hD000_0000, 5'd31);
    for (int i = 0; i < 32; i++) send_word(CMD_REMOVE, '0, 5'(i));
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 80 : (ph == 3) ? 28 : 0;
      recv_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 28 : 0;
      if (ph == 1) hold_cycles = 2000;
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) send_word(CMD_BLOCK, pick_key(), 5'($urandom));
        else if (roll < 60) send_word(CMD_UNBLOCK, pick_key(), 5'($urandom));
        else if (roll < 80) send_word(CMD_REMOVE, $urandom, 5'($urandom));
        else send_word(CMD_PEEK, pick_key(), 5'($urandom));
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    $display("covered %0d result words: all four commands, full and empty pool,",
             answered);
    $display("head/middle/tail removal, and four handshake pacing phases");
    if (fail_count == 0) begin
      $display("semaphore_wait_queue_table_core regression: pass");
    end else begin
      $display("semaphore_wait_queue_table_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
